>>> src/float32_subtract_unit_macros.svh
// Assertion macros for the float32 subtract unit
`ifndef FLOAT32_SUBTRACT_UNIT_MACROS_SVH
`define FLOAT32_SUBTRACT_UNIT_MACROS_SVH
// assert that a implies b at the same edge
`define FSU_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// assert that a implies b at the next edge
`define FSU_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

>>> src/fsub_pkg.sv
// ----------------------------------------------------------------------------
// fsub_pkg
// Types and constants shared by the float32 subtract unit.
// ----------------------------------------------------------------------------
package fsub_pkg;
  typedef struct packed {
    logic [31:0] minuend;
    logic [31:0] subtrahend;
  } fsub_in_t;

  typedef struct packed {
    logic [31:0] difference;
    logic        overflow;
  } fsub_out_t;

  localparam logic [7:0]  EXP_MAX    = 8'hff;
  localparam logic [23:0] HIDDEN_BIT = 24'h800000;
endpackage

>>> src/float32_subtract_unit.sv
// Path: an accepted input is held in the operand register, which feeds the
// datapath; the result register loads whenever no held result is stalled.
// Throughput: one subtraction per cycle while out_stall holds no result, set
// by the single-pass datapath between the input and result registers.
// Reset: synchronous active-low rst_n clears both valid flags.
// ----------------------------------------------------------------------------
// float32_subtract_unit
// IEEE single-precision subtract with input and result registers.
// ----------------------------------------------------------------------------
module float32_subtract_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fsub_pkg::fsub_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fsub_pkg::fsub_out_t out_data
);
  import fsub_pkg::*;
  `include "float32_subtract_unit_macros.svh"

  logic      op_vld_r, res_vld_r;
  fsub_in_t  op_r;
  fsub_out_t res_r, res_nxt;
  logic      adv;

  // pipeline advances unless a held result is stalled
  assign adv      = !(res_vld_r && out_stall);
  assign in_stall = op_vld_r && !adv;

  fsub_core u_core (.op(op_r), .res(res_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        res_vld_r <= op_vld_r;
        op_vld_r  <= in_valid;
      end else if (!op_vld_r) begin
        op_vld_r  <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= res_nxt;
    if (!in_stall && in_valid) op_r <= in_data;
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  `FSU_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `FSU_ASSERT_IMPL(a_stall, clk, rst_n, in_stall, op_vld_r && res_vld_r, "stall without full pipe")
  `FSU_ASSERT_NEXT(a_move, clk, rst_n, op_vld_r && !in_stall, out_valid, "operand lost")
endmodule

>>> src/fsub_core.sv
// ----------------------------------------------------------------------------
// fsub_core
// Combinational align, add, normalize and round for one subtraction.
// ----------------------------------------------------------------------------
module fsub_core (
  input  fsub_pkg::fsub_in_t  op,
  output fsub_pkg::fsub_out_t res
);
  import fsub_pkg::*;

  logic        s1, s2, first_big, pick2, same, mcarry, up;
  logic [7:0]  e1, e2, e1a, e2a, tde, es, esi, eyd, eyr, eyri, ey;
  logic [8:0]  te;
  logic [4:0]  de, se;
  logic [23:0] m1a, m2a, ms, mi;
  logic [22:0] my;
  logic [54:0] wide;
  logic        tstck, stck, ovf1, ovf2, sy, ss;
  logic [26:0] al, mye;
  logic [25:0] myd, myf;
  logic [24:0] myr;
  logic [9:0]  eyf;
  logic [56:0] dshift;

  always_comb begin
    s1  = op.minuend[31];
    s2  = ~op.subtrahend[31];
    e1  = op.minuend[30:23];
    e2  = op.subtrahend[30:23];
    m1a = (e1 != 8'd0) ? ({1'b0, op.minuend[22:0]} | HIDDEN_BIT) : {1'b0, op.minuend[22:0]};
    m2a = (e2 != 8'd0) ? ({1'b0, op.subtrahend[22:0]} | HIDDEN_BIT)
                       : {1'b0, op.subtrahend[22:0]};
    e1a = (e1 != 8'd0) ? e1 : 8'd1;
    e2a = (e2 != 8'd0) ? e2 : 8'd1;
    // exponent difference, capped at 31
    te        = {1'b0, e1a} + {1'b0, ~e2a};
    first_big = te[8];
    tde       = first_big ? (te[7:0] + 8'd1) : ~te[7:0];
    de        = (tde[7:5] != 3'd0) ? 5'd31 : tde[4:0];
    pick2     = (de == 5'd0) ? !(m1a > m2a) : !first_big;
    ms = pick2 ? m2a : m1a;
    mi = pick2 ? m1a : m2a;
    es = pick2 ? e2a : e1a;
    ss = pick2 ? s2 : s1;
    // align smaller mantissa with guard and sticky bits
    wide  = {mi, 31'd0} >> de;
    tstck = (wide[28:0] != 29'd0);
    al    = {1'b0, wide[54:29]};
    same  = (s1 == s2);
    mye   = same ? ({1'b0, ms, 2'b00} + al) : ({1'b0, ms, 2'b00} - al);
    esi   = es + 8'd1;
    mcarry = mye[26];
    ovf1 = 1'b0;
    if (mcarry) begin
      if (esi == EXP_MAX) begin
        eyd  = EXP_MAX;
        myd  = 26'h2000000;
        ovf1 = 1'b1;
      end else begin
        eyd = esi;
        myd = mye[26:1];
      end
      stck = tstck | mye[0];
    end else begin
      eyd  = es;
      myd  = mye[25:0];
      stck = tstck;
    end
    // leading zero count
    se = 5'd26;
    for (int i = 0; i < 26; i++) begin
      if (myd[i]) se = 5'(25 - i);
    end
    eyf = {2'b00, eyd} - {5'd0, se};
    dshift = {31'd0, myd} << (eyd - 8'd1) % 32;
    if (!eyf[9] && eyf != 10'd0) begin
      eyr = eyf[7:0];
      myf = myd << se;
    end else begin
      eyr = 8'd0;
      myf = dshift[25:0];
    end
    // round to nearest per guard, round and sticky
    up   = myf[1] && (myf[0] || (!stck && myf[2]) || (stck && same));
    myr  = {1'b0, myf[25:2]} + {24'd0, up};
    eyri = eyr + 8'd1;
    ovf2 = 1'b0;
    if (myr[24]) begin
      ey   = eyri;
      my   = 23'd0;
      ovf2 = (eyri == EXP_MAX);
    end else if (myr[23:0] == 24'd0) begin
      ey = 8'd0;
      my = 23'd0;
    end else begin
      ey = (myr[23] && eyr == 8'd0) ? 8'd1 : eyr;
      my = myr[22:0];
    end
    sy = (ey == 8'd0 && my == 23'd0) ? (s1 & s2) : ss;
    res.difference = {sy, ey, my};
    res.overflow   = (ovf1 | ovf2) && e1 != EXP_MAX && e2 != EXP_MAX;
  end
endmodule

>>> bench/fsub_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsub_checker
// Watches both channels of the float32 subtract unit, computes the expected
// difference and overflow for every input transfer and compares each result
// transfer against the oldest pending expectation.
// ----------------------------------------------------------------------------
module fsub_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  fsub_pkg::fsub_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  fsub_pkg::fsub_out_t out_data,
  output int                  fail_count,
  output int                  pending_count,
  output int                  result_count
);
  import fsub_pkg::*;

  fsub_out_t diff_queue[$];

  // leading zeros of a 26-bit value
  function automatic int unsigned lead_zeros(logic [25:0] v);
    for (int i = 0; i < 26; i++) begin
      if (v[25-i]) return i;
    end
    return 26;
  endfunction

  // bit-exact difference of two single-precision patterns
  function automatic fsub_out_t predict_difference(fsub_in_t op);
    logic        s1, s2, e1z, e2z, first_big, pick2, same, stck, up, ovf1, ovf2;
    logic [7:0]  e1, e2, e1a, e2a, tde, es, esi, eyd, eyr, eyri, ey;
    logic [8:0]  te;
    logic [4:0]  de;
    logic [22:0] m1, m2, my;
    logic [23:0] m1a, m2a, ms, mi;
    logic [62:0] wide;
    logic [26:0] al, mye, myf;
    logic [25:0] myd;
    logic [24:0] myr;
    logic        ss, sy, g, r, l;
    int unsigned se;
    int          eyf;
    fsub_out_t   res;
    s1 = op.minuend[31];
    s2 = ~op.subtrahend[31];
    e1 = op.minuend[30:23];
    e2 = op.subtrahend[30:23];
    m1 = op.minuend[22:0];
    m2 = op.subtrahend[22:0];
    e1z = (e1 == 0);
    e2z = (e2 == 0);
    m1a = e1z ? {1'b0, m1} : {1'b1, m1};
    m2a = e2z ? {1'b0, m2} : {1'b1, m2};
    e1a = e1z ? 8'd1 : e1;
    e2a = e2z ? 8'd1 : e2;
    te = {1'b0, e1a} + {1'b0, ~e2a};
    first_big = te[8];
    tde = first_big ? te[7:0] + 8'd1 : ~te[7:0];
    de = (tde[7:5] != 0) ? 5'd31 : tde[4:0];
    pick2 = (de == 0) ? !(m1a > m2a) : !first_big;
    ms = pick2 ? m2a : m1a;
    mi = pick2 ? m1a : m2a;
    es = pick2 ? e2a : e1a;
    ss = pick2 ? s2 : s1;
    same = (s1 == s2);
    wide = ({39'd0, mi} << 31) >> de;
    stck = (wide[28:0] != 0);
    al = wide[55:29];
    mye = same ? ({3'd0, ms} << 2) + al : ({3'd0, ms} << 2) - al;
    esi = es + 8'd1;
    ovf1 = 0;
    ovf2 = 0;
    // carry out renormalizes
    if (mye[26]) begin
      if (esi == EXP_MAX) begin
        eyd = EXP_MAX;
        myd = 26'h2000000;
        ovf1 = 1;
      end else begin
        eyd = esi;
        myd = mye[26:1];
      end
      stck = stck | mye[0];
    end else begin
      eyd = es;
      myd = mye[25:0];
    end
    // normalize, or shift into a denormal
    se = lead_zeros(myd);
    eyf = int'(eyd) - int'(se);
    if (eyf > 0) begin
      eyr = eyf[7:0];
      myf = {1'b0, myd} << se;
    end else begin
      eyr = 0;
      myf = {1'b0, myd} << 5'(eyd - 8'd1);
    end
    g = myf[1];
    r = myf[0];
    l = myf[2];
    up = g && (r || (!stck && l) || (stck && same));
    myr = myf[26:2] + 25'(up);
    eyri = eyr + 8'd1;
    if (myr[24]) begin
      ey = eyri;
      my = 0;
      ovf2 = (eyri == EXP_MAX);
    end else if (myr[23:0] == 0) begin
      ey = 0;
      my = 0;
    end else begin
      ey = (myr[23] && eyr == 0) ? 8'd1 : eyr;
      my = myr[22:0];
    end
    sy = (ey == 0 && my == 0) ? (s1 & s2) : ss;
    res.difference = {sy, ey, my};
    res.overflow = (ovf1 | ovf2) && e1 != EXP_MAX && e2 != EXP_MAX;
    return res;
  endfunction

  // predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    fsub_out_t want;
    if (!rst_n) begin
      diff_queue.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_valid && !in_stall) diff_queue.push_back(predict_difference(in_data));
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (diff_queue.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = diff_queue.pop_front();
          if (want.difference !== out_data.difference ||
              want.overflow !== out_data.overflow) begin
            if (fail_count < 10)
              $display("ERROR: difference exp %h/%b got %h/%b", want.difference,
                       want.overflow, out_data.difference, out_data.overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= diff_queue.size();
  end
endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the float32 subtract unit: directed corner operands, then
// random ones biased toward close exponents, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
  import fsub_pkg::*;

  localparam int RANDOM_OPS = 450;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  fsub_in_t  in_data;
  fsub_out_t out_data;
  int        fail_count, pending_count, result_count, sent_count;
  int        cycle_count = 0;
  logic [31:0] corner_a[$], corner_b[$];

  float32_subtract_unit dut (.*);

  fsub_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // random result stall, mostly short, sometimes long
  initial begin
    int n;
    out_stall = 0;
    forever begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      repeat (n) @(posedge clk) out_stall <= 0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      repeat (n) @(posedge clk) out_stall <= 1;
    end
  end

  function automatic logic [31:0] rand_float(logic [7:0] ex);
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  // called just after clk rises; holds the transfer until it is accepted
  task automatic send_op(logic [31:0] a, logic [31:0] b);
    int gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{minuend: a, subtrahend: b};
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  initial begin
    logic [7:0] ea, eb;
    sent_count = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    // directed: zeros, equal values, denormals, top exponent, far exponents
    corner_a = '{32'h0, 32'h80000000, 32'h3f800000, 32'h00000001, 32'h007fffff,
                 32'h7f7fffff, 32'h7f7fffff, 32'h7f800000, 32'h7fffffff, 32'h3f800000,
                 32'h4b800000, 32'h00800000, 32'hffffffff, 32'h3f800001, 32'h00000000,
                 32'h7f000000, 32'h40000000, 32'h3f7fffff, 32'hff7fffff, 32'h80800000};
    corner_b = '{32'h0, 32'h0, 32'h3f800000, 32'h80000001, 32'h807fffff,
                 32'hff7fffff, 32'h7f7fffff, 32'h7f800000, 32'hffffffff, 32'h33800000,
                 32'h3f800000, 32'h00000001, 32'h00000000, 32'h3f800000, 32'h80000000,
                 32'hff000000, 32'h3fffffff, 32'h3f800000, 32'h7f7fffff, 32'h00000001};
    foreach (corner_a[i]) send_op(corner_a[i], corner_b[i]);
    // random: mostly close exponents so that cancellation and rounding occur
    repeat (RANDOM_OPS) begin
      case ($urandom_range(0, 5))
        0: begin ea = 8'($urandom); eb = 8'($urandom); end
        1: begin ea = 8'($urandom_range(0, 2)); eb = 8'($urandom_range(0, 2)); end
        2: begin ea = 8'($urandom_range(250, 255)); eb = 8'($urandom_range(250, 255)); end
        default: begin
          ea = 8'($urandom);
          eb = ea + 8'($urandom_range(0, 4)) - 8'd2;
        end
      endcase
      send_op(rand_float(ea), rand_float(eb));
    end
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d subtractions (%0d corner pairs), %0d results checked.",
             sent_count, corner_a.size(), result_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
